// ----- sv/lhp_pkg.sv -----
// ----------------------------------------------------------------------------
// lhp_pkg
// Shared types, constants and codes for the latency histogram core.
// ----------------------------------------------------------------------------
`default_nettype none

package lhp_pkg;

  // Default number of histogram buckets.
  localparam int BUCKETS_DEFAULT = 4096;

  // Field widths of the words on the channels.
  localparam int LAT_W   = 48;
  localparam int PPM_W   = 20;
  localparam int VAL_W   = 24;
  localparam int CNT_W   = 40;
  localparam int START_W = 16;
  localparam int BW_W    = 11;
  localparam int CFGV_W  = 16;

  // Bucket counter and total widths.
  localparam int BCNT_W  = 32;
  localparam int TOTAL_W = 64;

  // Start offset in nanoseconds; a bucket width in nanoseconds fits the divisor.
  localparam int START_NS_W = START_W + 10;

  // Divider geometry: 48-bit dividend, 21-bit divisor, four quotient bits per step.
  localparam int DIV_DW     = LAT_W;
  localparam int DIV_RW     = 21;
  localparam int DIV_QW     = LAT_W;
  localparam int DIGIT_W    = 4;
  localparam int DIGITS_W   = 5;
  localparam int REC_DIGITS = DIV_DW / DIGIT_W;

  // Partial product width of a 32 by 20 multiply, and of total times ppm.
  localparam int PROD_W = 32 + PPM_W;
  localparam int QX_W   = TOTAL_W + PPM_W;

  // Arithmetic constants.
  localparam int NS_PER_US = 1000;
  localparam int PPM_ONE   = 1000000;
  localparam logic [CNT_W-1:0]  CNT_MAX   = '1;
  localparam logic [VAL_W-1:0]  VAL_OVERFLOW = '1;

  // Configuration register indexes.
  typedef enum logic {
    REG_HIST_START   = 1'b0,
    REG_BUCKET_WIDTH = 1'b1
  } reg_index_t;

  // Operation codes.
  typedef enum logic {
    FUNC_RECORD = 1'b0,
    FUNC_QUERY  = 1'b1
  } func_t;

  // Input word.
  typedef struct packed {
    func_t            func;
    logic [LAT_W-1:0] latency_ns;
    logic [PPM_W-1:0] quantile_ppm;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic signed [VAL_W-1:0] bucket_value_us;
    logic [CNT_W-1:0]        sample_count;
  } out_word_t;

  // Configuration write word.
  typedef struct packed {
    reg_index_t        index;
    logic [CFGV_W-1:0] value;
  } cfg_word_t;

  // Request to the divider.
  typedef struct packed {
    logic                start;
    logic [DIV_DW-1:0]   dividend;
    logic [DIV_RW-1:0]   divisor;
    logic [DIGITS_W-1:0] digits;
  } div_req_t;

endpackage

`default_nettype wire

// ----- sv/lhp_stream_if.sv -----
// ----------------------------------------------------------------------------
// lhp_stream_if
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
`default_nettype none

interface lhp_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// ----- sv/lhp_ram.sv -----
// ----------------------------------------------------------------------------
// lhp_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lhp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- sv/lhp_div.sv -----
// ----------------------------------------------------------------------------
// lhp_div
// Iterative restoring divider, four quotient bits per cycle. The dividend is
// left-aligned; the requested number of digits is taken from its top.
// ----------------------------------------------------------------------------
`default_nettype none

module lhp_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire lhp_pkg::div_req_t              req,
  output logic                                done,
  output logic [lhp_pkg::DIV_QW-1:0]          quotient
);

  localparam int DW = lhp_pkg::DIV_DW;
  localparam int RW = lhp_pkg::DIV_RW;
  localparam int QW = lhp_pkg::DIV_QW;
  localparam int GW = lhp_pkg::DIGIT_W;

  logic                         busy;
  logic [lhp_pkg::DIGITS_W-1:0] cnt;
  logic [lhp_pkg::DIGITS_W-1:0] digits;
  logic [DW-1:0]                dvd;
  logic [RW-1:0]                rem;
  logic [RW-1:0]                divisor;
  logic [RW-1:0]                rem_next;
  logic [GW-1:0]                qdigit;

  // One radix-16 step: four compare-and-subtract stages on the remainder.
  always_comb begin
    logic [RW:0]   trial;
    logic [RW-1:0] r;
    r      = rem;
    qdigit = '0;
    for (int k = 0; k < GW; k++) begin
      trial = {r, dvd[DW-1-k]};
      if (trial >= {1'b0, divisor}) begin
        trial         = trial - {1'b0, divisor};
        qdigit[GW-1-k] = 1'b1;
      end
      r = trial[RW-1:0];
    end
    rem_next = r;
  end

  // Control: counts digits and flags completion in the cycle after the last.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == digits - 1'b1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd      <= req.dividend;
      divisor  <= req.divisor;
      digits   <= req.digits;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd      <= {dvd[DW-GW-1:0], {GW{1'b0}}};
      rem      <= rem_next;
      quotient <= {quotient[QW-GW-1:0], qdigit};
    end
  end

endmodule

`default_nettype wire

// ----- sv/latency_histogram_percentile_core.sv -----
// ----------------------------------------------------------------------------
// latency_histogram_percentile_core
// Latency histogram in a bucket RAM with record and percentile query words.
//
//   Channel  Dir  Word        Contents
//   in       in   in_word_t   func, latency_ns, quantile_ppm
//   out      out  out_word_t  bucket_value_us, sample_count (one per query)
//   cfg      in   cfg_word_t  index, value (register write, always ready)
//
// A record is a 12-step pass of the radix-16 divider (latency minus start
// offset over bucket width, both in nanoseconds) and one RAM read-modify-write;
// a latency below the start offset skips the divider. A query is two 32x20
// multiplies, a step that forms the product, and a three-stage scan of one
// bucket per cycle, which stops at the answering bucket. After reset a clearing
// pass writes zero to all BUCKETS entries, one per cycle, while in.ready stays
// low. A finished result waits in the output register; a second query stalls
// at its end until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module latency_histogram_percentile_core #(
  parameter int BUCKETS = lhp_pkg::BUCKETS_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  lhp_stream_if.sink   in,
  lhp_stream_if.source out,
  lhp_stream_if.sink   cfg
);

  localparam int IDXW = $clog2(BUCKETS);
  localparam int SUMW = lhp_pkg::BCNT_W + IDXW;
  localparam int ACCW = SUMW + lhp_pkg::PPM_W;
  localparam int CMPW = (ACCW > lhp_pkg::QX_W) ? ACCW : lhp_pkg::QX_W;
  localparam int VW   = (IDXW + 12 > lhp_pkg::VAL_W) ? IDXW + 12 : lhp_pkg::VAL_W;
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(BUCKETS - 1);
  localparam logic [IDXW-1:0] SCAN_END = IDXW'(BUCKETS - 2);

  typedef enum logic [9:0] {
    ST_CLR    = 10'b00_0000_0001,
    ST_IDLE   = 10'b00_0000_0010,
    ST_DIV    = 10'b00_0000_0100,
    ST_RD     = 10'b00_0000_1000,
    ST_WR     = 10'b00_0001_0000,
    ST_MUL_LO = 10'b00_0010_0000,
    ST_MUL_HI = 10'b00_0100_0000,
    ST_QLOAD  = 10'b00_1000_0000,
    ST_SCAN   = 10'b01_0000_0000,
    ST_FIN    = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // Configuration and running total.
  logic [lhp_pkg::START_W-1:0]    range_start_us;
  logic [lhp_pkg::BW_W-1:0]       bucket_width_us;
  logic [lhp_pkg::BW_W-1:0]       eff_width;
  logic [lhp_pkg::START_NS_W-1:0] start_ns;
  logic [lhp_pkg::DIV_RW-1:0]     width_ns;
  logic [lhp_pkg::TOTAL_W-1:0]    total_count;

  // Record and query working registers.
  logic [IDXW-1:0]              rec_idx;
  logic [lhp_pkg::PPM_W-1:0]    ppm;
  logic [lhp_pkg::PROD_W-1:0]   p_lo;
  logic [lhp_pkg::PROD_W-1:0]   p_hi;
  logic [lhp_pkg::QX_W-1:0]     qx;
  logic [ACCW-1:0]              acc;
  logic [ACCW-1:0]              acc_next;
  logic [lhp_pkg::PROD_W-1:0]   cd;
  logic [IDXW-1:0]              scan_addr;
  logic [IDXW-1:0]              scan_idx;
  logic                         scan_vld;
  logic [IDXW-1:0]              cd_idx;
  logic                         cd_vld;
  logic [IDXW-1:0]              found;
  logic [IDXW-1:0]              clr_addr;

  // Output register.
  logic                  out_valid;
  lhp_pkg::out_word_t    out_data;

  // Divider.
  lhp_pkg::div_req_t            div_req;
  logic                         div_done;
  logic [lhp_pkg::DIV_QW-1:0]   div_q;

  // Bucket RAM.
  logic                        mem_we;
  logic [IDXW-1:0]             mem_waddr;
  logic [lhp_pkg::BCNT_W-1:0]  mem_wdata;
  logic [IDXW-1:0]             mem_raddr;
  logic [lhp_pkg::BCNT_W-1:0]  mem_rdata;

  // Derived values.
  logic                        rec_below;
  logic                        hit;
  logic                        out_free;
  logic [VW-1:0]               vprod;
  logic                        in_acc;

  assign eff_width = (bucket_width_us == '0) ? lhp_pkg::BW_W'(1) : bucket_width_us;
  assign in_acc    = in.valid && in.ready;
  assign in.ready  = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign out.valid = out_valid;
  assign out.data  = out_data;
  assign out_free  = !out_valid || out.ready;

  // Start offset and bucket width scaled to nanoseconds.
  assign start_ns  = lhp_pkg::START_NS_W'(range_start_us) *
                     lhp_pkg::START_NS_W'(lhp_pkg::NS_PER_US);
  assign width_ns  = lhp_pkg::DIV_RW'(eff_width) * lhp_pkg::DIV_RW'(lhp_pkg::NS_PER_US);
  assign rec_below = in.data.latency_ns < lhp_pkg::LAT_W'(start_ns);

  // The running sum is kept as (sum + 1) * 1e6; a bucket is reached when that
  // exceeds total * ppm, which is the same as sum reaching the goal.
  assign acc_next  = acc + ACCW'(cd);
  assign hit       = CMPW'(qx) < CMPW'(acc_next);
  assign vprod     = VW'(found) * VW'(eff_width) + VW'(range_start_us);

  // Divider for the record bucket index.
  lhp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  // Bucket counters.
  lhp_ram #(
    .WIDTH (lhp_pkg::BCNT_W),
    .DEPTH (BUCKETS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Divider request: bucket index straight from nanoseconds.
  always_comb begin
    div_req = '0;
    case (state)
      ST_IDLE: begin
        if (in_acc && in.data.func == lhp_pkg::FUNC_RECORD && !rec_below) begin
          div_req.start    = 1'b1;
          div_req.dividend = in.data.latency_ns - lhp_pkg::LAT_W'(start_ns);
          div_req.divisor  = width_ns;
          div_req.digits   = lhp_pkg::DIGITS_W'(lhp_pkg::REC_DIGITS);
        end
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  // RAM port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rec_idx;
    mem_wdata = mem_rdata + 1'b1;
    mem_raddr = rec_idx;
    case (state)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      ST_WR: begin
        mem_we = 1'b1;
      end
      ST_SCAN: begin
        mem_raddr = scan_addr;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLR: begin
        if (clr_addr == LAST_IDX) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in.data.func == lhp_pkg::FUNC_RECORD) begin
            state_next = rec_below ? ST_RD : ST_DIV;
          end else begin
            state_next = ST_MUL_LO;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_RD;
        end
      end
      ST_RD:     state_next = ST_WR;
      ST_WR:     state_next = ST_IDLE;
      ST_MUL_LO: state_next = ST_MUL_HI;
      ST_MUL_HI: state_next = ST_QLOAD;
      ST_QLOAD:  state_next = ST_SCAN;
      ST_SCAN: begin
        if (cd_vld && (hit || cd_idx == SCAN_END)) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLR;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLR;
      clr_addr        <= '0;
      total_count     <= '0;
      range_start_us  <= '0;
      bucket_width_us <= lhp_pkg::BW_W'(1);
      out_valid       <= 1'b0;
      scan_vld        <= 1'b0;
      cd_vld          <= 1'b0;
    end else begin
      state <= state_next;

      // Clearing pass address.
      if (state == ST_CLR) begin
        clr_addr <= clr_addr + 1'b1;
      end

      // Sample total.
      if (state == ST_WR) begin
        total_count <= total_count + 1'b1;
      end

      // Configuration writes.
      if (cfg.valid) begin
        case (cfg.data.index)
          lhp_pkg::REG_HIST_START:   range_start_us  <= cfg.data.value[lhp_pkg::START_W-1:0];
          lhp_pkg::REG_BUCKET_WIDTH: bucket_width_us <= cfg.data.value[lhp_pkg::BW_W-1:0];
          default: begin
            range_start_us <= range_start_us;
          end
        endcase
      end

      // Scan pipeline valids: read data, then scaled count.
      scan_vld <= (state == ST_SCAN);
      cd_vld   <= scan_vld && (state == ST_SCAN);

      // Result handshake.
      if (state == ST_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    // Bucket index of a record.
    if (in_acc && in.data.func == lhp_pkg::FUNC_RECORD && rec_below) begin
      rec_idx <= LAST_IDX;
    end else if (state == ST_DIV && div_done) begin
      rec_idx <= (div_q >= lhp_pkg::DIV_QW'(BUCKETS)) ? LAST_IDX : div_q[IDXW-1:0];
    end

    // Query operands and partial products.
    if (in_acc) begin
      ppm <= in.data.quantile_ppm;
    end
    if (state == ST_MUL_LO) begin
      p_lo <= lhp_pkg::PROD_W'(total_count[31:0]) * lhp_pkg::PROD_W'(ppm);
    end
    if (state == ST_MUL_HI) begin
      p_hi <= lhp_pkg::PROD_W'(total_count[63:32]) * lhp_pkg::PROD_W'(ppm);
    end

    // Full product total * ppm and scan start.
    if (state == ST_QLOAD) begin
      qx        <= {p_hi, 32'b0} + lhp_pkg::QX_W'(p_lo);
      acc       <= ACCW'(lhp_pkg::PPM_ONE);
      scan_addr <= '0;
    end

    // Bucket scan: read, scale by 1e6, then accumulate and compare.
    if (state == ST_SCAN) begin
      scan_addr <= scan_addr + 1'b1;
      scan_idx  <= scan_addr;
      cd        <= lhp_pkg::PROD_W'(mem_rdata) * lhp_pkg::PROD_W'(lhp_pkg::PPM_ONE);
      cd_idx    <= scan_idx;
      if (cd_vld) begin
        acc <= acc_next;
        if (hit) begin
          found <= cd_idx;
        end else if (cd_idx == SCAN_END) begin
          found <= LAST_IDX;
        end
      end
    end

    // Result word.
    if (state == ST_FIN && out_free) begin
      out_data.bucket_value_us <= (found == LAST_IDX) ? lhp_pkg::VAL_OVERFLOW :
                                  vprod[lhp_pkg::VAL_W-1:0];
      out_data.sample_count    <= (total_count > lhp_pkg::TOTAL_W'(lhp_pkg::CNT_MAX)) ?
                                  lhp_pkg::CNT_MAX : total_count[lhp_pkg::CNT_W-1:0];
    end
  end

  // The bucket RAM is never written while a query scans it.
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !mem_we)
    else $error("bucket RAM written during scan");

  // Each record write-back adds exactly one to the total.
  a_total_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WR) |=> (total_count == $past(total_count) + 1'b1))
    else $error("total not advanced by record");

  // Divider completion only arrives while the sequencer waits for it.
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider result arrived out of sequence");

  // The scan never sums the overflow bucket.
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && cd_vld) |-> (cd_idx != LAST_IDX))
    else $error("scan reached overflow bucket");

endmodule

`default_nettype wire
